// ===== src/dual_data_pointer_unit_defines.svh =====
// Assertion macros for the dual data pointer unit.
// The enclosing module must provide clk_i and rst_ni.
`ifndef DUAL_DATA_POINTER_UNIT_DEFINES_SVH
`define DUAL_DATA_POINTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define DDP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dual data pointer check failed");
// Check that a condition holds whenever a trigger fires.
`define DDP_ASSERT_IMPL(name, trig, prop) \
  `DDP_ASSERT(name, (trig) |-> (prop))
`else
`define DDP_ASSERT(name, prop)
`define DDP_ASSERT_IMPL(name, trig, prop)
`endif

`endif

// ===== src/ddp_pkg.sv =====
package ddp_pkg;

  // Operation codes carried in the mode field.
  localparam logic [2:0] MODE_STEP       = 3'd0;
  localparam logic [2:0] MODE_LOAD       = 3'd1;
  localparam logic [2:0] MODE_CODE_READ  = 3'd2;
  localparam logic [2:0] MODE_JUMP       = 3'd3;
  localparam logic [2:0] MODE_XDATA      = 3'd4;
  localparam logic [2:0] MODE_WRITE_SEL  = 3'd5;
  localparam logic [2:0] MODE_TOGGLE_SEL = 3'd6;

  // Select byte bit positions.
  localparam int unsigned SEL_PTR_BIT  = 0;
  localparam int unsigned SEL_SWAP_BIT = 5;
  localparam int unsigned SEL_DEC0_BIT = 6;
  localparam int unsigned SEL_DEC1_BIT = 7;

  // Code space size, a power of two from 256 to 65536.
  localparam int unsigned CodeSpace = 65536;
  localparam logic [15:0] CodeMask  = 16'(CodeSpace - 1);

endpackage

// ===== src/ddp_in_if.sv =====
interface ddp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] immediate;
  logic [7:0]  acc_value;

  modport source (output valid, output mode, output immediate, output acc_value,
                  input ready);
  modport sink   (input valid, input mode, input immediate, input acc_value,
                  output ready);
endinterface

// ===== src/ddp_out_if.sv =====
interface ddp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;
  logic        pointer_used;
  logic [7:0]  select_after;
  logic [15:0] pointer_value;

  modport source (output valid, output address, output pointer_used,
                  output select_after, output pointer_value, input ready);
  modport sink   (input valid, input address, input pointer_used,
                  input select_after, input pointer_value, output ready);
endinterface

// ===== src/dual_data_pointer_unit.sv =====
// Dual data pointer unit: two 16-bit data pointers and a select byte, as in
// an 8051-family core. Each word on in_i is one pointer operation and yields
// exactly one word on out_o. A word is taken into an input register, then
// executed into the output register, where the pointer and select state
// update as well. Throughput is one word per cycle while out_o is ready; a
// word passes the input register and then the output register before it
// shows on out_o. The input register takes one more word while a result
// waits, and in_i stalls only when both registers hold words and the
// output is not drained in that cycle. Reset clears both pointers and the
// select byte.
`include "dual_data_pointer_unit_defines.svh"

module dual_data_pointer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ddp_in_if.sink    in_i,
  ddp_out_if.source out_o
);

  // Input register.
  logic        in_valid_q;
  logic [2:0]  mode_q;
  logic [15:0] imm_q;
  logic [7:0]  acc_q;

  // Architectural state.
  logic [15:0] ptr0_q, ptr0_d;
  logic [15:0] ptr1_q, ptr1_d;
  logic [7:0]  sel_q, sel_d;

  // Output register.
  logic        out_valid_q;
  logic [15:0] addr_q, addr_d;
  logic        used_q, used_d;
  logic [7:0]  sel_out_q;
  logic [15:0] pval_q, pval_d;

  logic        advance;
  logic        which;
  logic        dec;
  logic        swap;
  logic [15:0] cur_ptr;
  logic [15:0] stepped;
  logic [15:0] code_addr;

  // Execute the held word whenever the output register is free or drains now.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      imm_q  <= in_i.immediate;
      acc_q  <= in_i.acc_value;
    end
  end

  // Pointer picked by the select byte before the operation.
  assign which     = sel_q[ddp_pkg::SEL_PTR_BIT];
  assign cur_ptr   = which ? ptr1_q : ptr0_q;
  // Per-pointer direction bit turns the step into a decrement.
  assign dec       = which ? sel_q[ddp_pkg::SEL_DEC1_BIT] : sel_q[ddp_pkg::SEL_DEC0_BIT];
  assign stepped   = dec ? cur_ptr - 16'd1 : cur_ptr + 16'd1;
  // Code address: pointer plus accumulator, folded into code space.
  assign code_addr = (cur_ptr + {8'd0, acc_q}) & ddp_pkg::CodeMask;

  always_comb begin
    ptr0_d = ptr0_q;
    ptr1_d = ptr1_q;
    sel_d  = sel_q;
    addr_d = 16'd0;
    used_d = which;
    swap   = 1'b0;
    case (mode_q)
      ddp_pkg::MODE_STEP: begin
        if (which) ptr1_d = stepped;
        else       ptr0_d = stepped;
        swap = 1'b1;
      end
      ddp_pkg::MODE_LOAD: begin
        if (which) ptr1_d = imm_q;
        else       ptr0_d = imm_q;
        swap = 1'b1;
      end
      ddp_pkg::MODE_CODE_READ: begin
        addr_d = code_addr;
        swap   = 1'b1;
      end
      ddp_pkg::MODE_JUMP: begin
        // Jump never toggles the selection.
        addr_d = code_addr;
      end
      ddp_pkg::MODE_XDATA: begin
        addr_d = cur_ptr;
        swap   = 1'b1;
      end
      ddp_pkg::MODE_WRITE_SEL: begin
        sel_d  = imm_q[7:0];
        used_d = imm_q[ddp_pkg::SEL_PTR_BIT];
      end
      ddp_pkg::MODE_TOGGLE_SEL: begin
        sel_d  = sel_q ^ 8'h01;
        used_d = !which;
      end
      default: begin
        // Unused code: change nothing.
      end
    endcase
    // Auto-toggle: flip the pointer choice after a pointer operation.
    if (swap && sel_q[ddp_pkg::SEL_SWAP_BIT]) begin
      sel_d = sel_q ^ 8'h01;
    end
    // Report the pointer used, as it stands after the operation.
    pval_d = used_d ? ptr1_d : ptr0_d;
  end

  // State advances only with an executed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr0_q <= 16'd0;
      ptr1_q <= 16'd0;
      sel_q  <= 8'd0;
    end else if (advance) begin
      ptr0_q <= ptr0_d;
      ptr1_q <= ptr1_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      addr_q    <= addr_d;
      used_q    <= used_d;
      sel_out_q <= sel_d;
      pval_q    <= pval_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.address       = addr_q;
  assign out_o.pointer_used  = used_q;
  assign out_o.select_after  = sel_out_q;
  assign out_o.pointer_value = pval_q;

  // An executed word always lands in the output register.
  `DDP_ASSERT_IMPL(a_adv_fills_out, advance, ##1 out_valid_q)
  // The select byte holds unless a word executes.
  `DDP_ASSERT_IMPL(a_sel_hold, !advance, ##1 $stable(sel_q))
  // A jump leaves the select byte untouched.
  `DDP_ASSERT_IMPL(a_jump_keeps_sel, advance && (mode_q == ddp_pkg::MODE_JUMP),
                   ##1 $stable(sel_q))
  // The shown select byte always matches the live state.
  `DDP_ASSERT_IMPL(a_sel_match, out_valid_q, sel_out_q == sel_q)

endmodule

// ===== bench/tb_dual_data_pointer_unit.sv =====
module tb_dual_data_pointer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The mode field has one code the block does not define; it must leave
  // every pointer and the select byte alone.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam int unsigned RandomWords = 1300;
  localparam int unsigned PhaseCount  = 4;
  localparam int unsigned ReportLimit = 10;
  // Two register stages from acceptance to result; allow a few more.
  localparam int unsigned DrainCycles = 8;

  // One operation word as it goes into the block.
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] immediate;
    logic [7:0]  acc_value;
  } op_word_t;

  // One result word as it comes out of the block.
  typedef struct packed {
    logic [15:0] address;
    logic        pointer_used;
    logic [7:0]  select_after;
    logic [15:0] pointer_value;
  } ptr_result_t;

  // Directed stimulus row: the operation, and where the answer is obvious
  // from reset or an extreme, the result typed in by hand.
  typedef struct {
    op_word_t    op;
    bit          typed;
    ptr_result_t res;
  } plan_row_t;

  localparam ptr_result_t NO_RESULT = '{default: '0};

  // Sender idle and receiver stall odds per phase, in percent: first no
  // idling at all, then a slow sender, then a slow receiver, then both.
  localparam int unsigned SendIdleByPhase[PhaseCount]  = '{0, 61, 0, 13};
  localparam int unsigned RecvStallByPhase[PhaseCount] = '{0, 0, 61, 13};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ddp_in_if  in_bus ();
  ddp_out_if out_bus ();

  dual_data_pointer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's state, advanced once per accepted word.
  logic [15:0] ptr_zero_q = '0;
  logic [15:0] ptr_one_q  = '0;
  logic [7:0]  sel_byte_q = '0;

  ptr_result_t expected_q[$];
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Directed words, walked from reset with no idling. The comments say what
  // each group of rows exercises.
  plan_row_t directed_plan[24] = '{
    // Everything reads zero right after reset.
    '{'{ddp_pkg::MODE_XDATA, 16'h0000, 8'h00}, 1'b1, '{16'h0000, 1'b0, 8'h00, 16'h0000}},
    // Increment pointer 0, then load the top value and wrap it to zero.
    '{'{ddp_pkg::MODE_STEP, 16'h0000, 8'h00}, 1'b1, '{16'h0000, 1'b0, 8'h00, 16'h0001}},
    '{'{ddp_pkg::MODE_LOAD, 16'hffff, 8'h00}, 1'b1, '{16'h0000, 1'b0, 8'h00, 16'hffff}},
    '{'{ddp_pkg::MODE_STEP, 16'h0000, 8'h00}, 1'b1, '{16'h0000, 1'b0, 8'h00, 16'h0000}},
    // Turn on decrement for pointer 0 and wrap downward from zero.
    '{'{ddp_pkg::MODE_WRITE_SEL, 16'h0040, 8'h00}, 1'b1, '{16'h0000, 1'b0, 8'h40, 16'h0000}},
    '{'{ddp_pkg::MODE_STEP, 16'h0000, 8'h00}, 1'b1, '{16'h0000, 1'b0, 8'h40, 16'hffff}},
    // Code read address wraps across the top of code space; jump lands at the top.
    '{'{ddp_pkg::MODE_CODE_READ, 16'h0000, 8'hff}, 1'b1, '{16'h00fe, 1'b0, 8'h40, 16'hffff}},
    '{'{ddp_pkg::MODE_JUMP, 16'h0000, 8'h00}, 1'b1, '{16'hffff, 1'b0, 8'h40, 16'hffff}},
    // Toggle over to pointer 1, still at zero.
    '{'{ddp_pkg::MODE_TOGGLE_SEL, 16'h0000, 8'h00}, 1'b1, '{16'h0000, 1'b1, 8'h41, 16'h0000}},
    '{'{ddp_pkg::MODE_LOAD, 16'h8000, 8'h00}, 1'b0, NO_RESULT},
    // Only the low byte of the immediate reaches the select byte.
    '{'{ddp_pkg::MODE_WRITE_SEL, 16'hffc1, 8'h00}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_STEP, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_STEP, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
    // Auto-toggle on: pointer operations flip the selection, jump does not.
    '{'{ddp_pkg::MODE_WRITE_SEL, 16'h00e1, 8'h00}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_STEP, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_CODE_READ, 16'h0000, 8'h80}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_JUMP, 16'h0000, 8'hff}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_XDATA, 16'hffff, 8'hff}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_LOAD, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
    // The undefined mode changes nothing, whatever its operands.
    '{'{MODE_UNUSED, 16'hffff, 8'hff}, 1'b0, NO_RESULT},
    // An explicit toggle flips once, with no extra auto-toggle on top.
    '{'{ddp_pkg::MODE_TOGGLE_SEL, 16'hffff, 8'hff}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_WRITE_SEL, 16'h0020, 8'h00}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_STEP, 16'h0000, 8'h00}, 1'b0, NO_RESULT},
    '{'{ddp_pkg::MODE_WRITE_SEL, 16'hff00, 8'h00}, 1'b0, NO_RESULT}
  };

  // Apply one operation to the shadow state and return the word the block
  // must produce for it.
  function automatic ptr_result_t apply_pointer_op(input op_word_t w);
    ptr_result_t res;
    logic [7:0]  sel_in;
    logic        which;
    logic        swap;
    logic        down;
    logic [15:0] cur;

    sel_in = sel_byte_q;
    which  = sel_in[ddp_pkg::SEL_PTR_BIT];
    cur    = which ? ptr_one_q : ptr_zero_q;
    swap   = 1'b0;
    res    = NO_RESULT;

    case (w.mode)
      ddp_pkg::MODE_STEP: begin
        down = which ? sel_in[ddp_pkg::SEL_DEC1_BIT] : sel_in[ddp_pkg::SEL_DEC0_BIT];
        cur  = down ? cur - 16'd1 : cur + 16'd1;
        swap = 1'b1;
      end
      ddp_pkg::MODE_LOAD: begin
        cur  = w.immediate;
        swap = 1'b1;
      end
      ddp_pkg::MODE_CODE_READ: begin
        res.address = (cur + {8'h00, w.acc_value}) & ddp_pkg::CodeMask;
        swap        = 1'b1;
      end
      ddp_pkg::MODE_JUMP: begin
        res.address = (cur + {8'h00, w.acc_value}) & ddp_pkg::CodeMask;
      end
      ddp_pkg::MODE_XDATA: begin
        res.address = cur;
        swap        = 1'b1;
      end
      ddp_pkg::MODE_WRITE_SEL: begin
        sel_byte_q = w.immediate[7:0];
      end
      ddp_pkg::MODE_TOGGLE_SEL: begin
        sel_byte_q[ddp_pkg::SEL_PTR_BIT] = ~sel_in[ddp_pkg::SEL_PTR_BIT];
      end
      default: begin
      end
    endcase

    // Write back the pointer that was active when the word came in.
    if (which) ptr_one_q = cur;
    else       ptr_zero_q = cur;

    if (swap && sel_in[ddp_pkg::SEL_SWAP_BIT])
      sel_byte_q[ddp_pkg::SEL_PTR_BIT] = ~sel_in[ddp_pkg::SEL_PTR_BIT];

    // Select writes report the pointer the new select byte picks.
    if (w.mode == ddp_pkg::MODE_WRITE_SEL || w.mode == ddp_pkg::MODE_TOGGLE_SEL)
      which = sel_byte_q[ddp_pkg::SEL_PTR_BIT];

    res.pointer_used  = which;
    res.select_after  = sel_byte_q;
    res.pointer_value = which ? ptr_one_q : ptr_zero_q;
    return res;
  endfunction

  // Random operation: mostly pointer operations, with enough select writes
  // to keep every mix of toggle and decrement bits in play.
  function automatic op_word_t random_word();
    op_word_t    w;
    int unsigned pick;

    pick = $urandom_range(99);
    if (pick < 70)      w.mode = 3'($urandom_range(4));
    else if (pick < 84) w.mode = ddp_pkg::MODE_WRITE_SEL;
    else if (pick < 95) w.mode = ddp_pkg::MODE_TOGGLE_SEL;
    else                w.mode = MODE_UNUSED;

    // Lean on the ends of the range so the wraps show up often.
    case ($urandom_range(7))
      0:       w.immediate = 16'h0000;
      1:       w.immediate = 16'hffff;
      2:       w.immediate = 16'hfffe;
      default: w.immediate = 16'($urandom);
    endcase

    case ($urandom_range(5))
      0:       w.acc_value = 8'h00;
      1:       w.acc_value = 8'hff;
      default: w.acc_value = 8'($urandom);
    endcase
    return w;
  endfunction

  // Present one word and hold it until the block takes it. Valid stays high
  // into the next word unless that word starts with an idle gap.
  task automatic drive_word(input op_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= w.mode;
    in_bus.immediate <= w.immediate;
    in_bus.acc_value <= w.acc_value;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // Stimulus: reset, directed rows, then random words across the idling
  // phases, then drain and report.
  initial begin
    ptr_result_t predicted;
    op_word_t    w;

    in_bus.valid     = 1'b0;
    in_bus.mode      = ddp_pkg::MODE_STEP;
    in_bus.immediate = '0;
    in_bus.acc_value = '0;
    out_bus.ready    = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      drive_word(directed_plan[i].op);
      predicted = apply_pointer_op(directed_plan[i].op);
      expected_q.push_back(directed_plan[i].typed ? directed_plan[i].res : predicted);
    end

    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      send_idle_pct  = SendIdleByPhase[phase];
      recv_stall_pct = RecvStallByPhase[phase];
      repeat (RandomWords / PhaseCount) begin
        w = random_word();
        drive_word(w);
        expected_q.push_back(apply_pointer_op(w));
      end
    end
    in_bus.valid <= 1'b0;

    // Wait out every pending result, then a few more cycles for strays.
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: stall at random, and check every word taken against the
  // oldest prediction.
  always @(posedge clk_i) begin : result_check
    ptr_result_t want;

    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("unexpected result word: addr %h used %b sel %h ptr %h",
                   out_bus.address, out_bus.pointer_used, out_bus.select_after,
                   out_bus.pointer_value);
      end else begin
        want = expected_q.pop_front();
        if (out_bus.address !== want.address ||
            out_bus.pointer_used !== want.pointer_used ||
            out_bus.select_after !== want.select_after ||
            out_bus.pointer_value !== want.pointer_value) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("mismatch: expected %h/%b/%h/%h, got %h/%b/%h/%h",
                     want.address, want.pointer_used, want.select_after,
                     want.pointer_value, out_bus.address, out_bus.pointer_used,
                     out_bus.select_after, out_bus.pointer_value);
        end
      end
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ddp_pkg.sv
src/ddp_in_if.sv
src/ddp_out_if.sv
src/dual_data_pointer_unit.sv
bench/tb_dual_data_pointer_unit.sv
